### sv/ist_pkg.sv
// shared types and constants of the interval subscription table
package ist_pkg;

   localparam int unsigned ID_W  = 6;
   localparam int unsigned IV_W  = 32;
   localparam int unsigned ST_W  = 2;
   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;

   localparam logic [IV_W-1:0] MAX_WAIT_RESET = 32'd1000000;
   localparam logic [IV_W-1:0] IV_ALL_ONES    = '1;

   // register index taken from the word address
   localparam logic REG_MAX_WAIT = 1'b0;

   localparam logic KIND_SUB   = 1'b0;
   localparam logic KIND_UNSUB = 1'b1;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_SUB = 2'd2;

   typedef struct packed {
      logic clear;   // write one empty slot during the clearing pass
      logic start;   // latch a request and restart the scan
      logic scan;    // read the next slot
      logic commit;  // update the table and load the result
   } cmd_type;

   typedef struct packed {
      logic addr_last;  // slot address at the final entry
      logic out_busy;   // result register full and stalled
   } sts_type;

endpackage

### sv/interval_subscription_table.sv
// interval subscription table: a new request is taken only after the slot scan of the last one is done
// a request walks every slot of the id-indexed memory, one read per cycle, then the TAIL
// state folds the last read and the COMMIT state writes the table and loads the result
// rsp_valid is set by a register loaded at the commit, which waits while the result is stalled
// after reset a clearing pass over every slot holds req_stall high
// reset empties the table, clears the running flag and sets max_wait_us to 1000000
module interval_subscription_table #(
   parameter int unsigned MAX_ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [ist_pkg::IV_W-1:0]      req_interval_us,
   input  logic [ist_pkg::ID_W-1:0]      req_target_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ist_pkg::ST_W-1:0]      rsp_status,
   output logic [ist_pkg::ID_W-1:0]      rsp_assigned_id,
   output logic                          rsp_active,
   output logic [ist_pkg::IV_W-1:0]      rsp_min_interval_us,
   output logic [ist_pkg::IV_W-1:0]      rsp_wait_interval_us,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ist_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [ist_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [ist_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   ist_pkg::cmd_type          cmd;
   ist_pkg::sts_type          sts;
   logic [ist_pkg::IV_W-1:0]  max_wait_ff, max_wait_in;
   logic                      csr_sel_max_wait;

   assign csr_pready       = 1'b1;
   assign csr_sel_max_wait = (csr_paddr[ist_pkg::CSR_AW-1] == ist_pkg::REG_MAX_WAIT);

   always_comb begin
      max_wait_in = max_wait_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_sel_max_wait) begin
         max_wait_in = csr_pwdata;
      end
      csr_prdata = csr_sel_max_wait ? max_wait_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wait_ff <= ist_pkg::MAX_WAIT_RESET;
      end else begin
         max_wait_ff <= max_wait_in;
      end
   end

   ist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ist_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_kind             (req_kind),
      .req_interval_us      (req_interval_us),
      .req_target_id        (req_target_id),
      .max_wait_us          (max_wait_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_assigned_id      (rsp_assigned_id),
      .rsp_active           (rsp_active),
      .rsp_min_interval_us  (rsp_min_interval_us),
      .rsp_wait_interval_us (rsp_wait_interval_us)
   );

endmodule

### sv/ist_ctrl.sv
// controller state machine of the interval subscription table
module ist_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ist_pkg::sts_type sts,
   output ist_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.addr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.addr_last) begin
               state_in = S_TAIL;
            end
         end
         // last read data is folded in during this cycle
         S_TAIL: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/ist_dpath.sv
// datapath of the interval subscription table: slot memory, scan and result register
module ist_dpath #(
   parameter int unsigned MAX_ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ist_pkg::cmd_type              cmd,
   output ist_pkg::sts_type              sts,
   input  logic                          req_kind,
   input  logic [ist_pkg::IV_W-1:0]      req_interval_us,
   input  logic [ist_pkg::ID_W-1:0]      req_target_id,
   input  logic [ist_pkg::IV_W-1:0]      max_wait_us,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ist_pkg::ST_W-1:0]      rsp_status,
   output logic [ist_pkg::ID_W-1:0]      rsp_assigned_id,
   output logic                          rsp_active,
   output logic [ist_pkg::IV_W-1:0]      rsp_min_interval_us,
   output logic [ist_pkg::IV_W-1:0]      rsp_wait_interval_us
);

   localparam int unsigned IW   = $clog2(MAX_ENTRIES);
   localparam int unsigned CW   = (IW > ist_pkg::ID_W) ? IW : ist_pkg::ID_W;
   localparam int unsigned CNTW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned MW   = ist_pkg::IV_W + 1;

   // slot memory indexed by id: {used, interval}
   logic [MW-1:0] mem [MAX_ENTRIES];

   logic [IW-1:0]            addr_ff, addr_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [IW-1:0]            rd_idx_ff;
   logic [MW-1:0]            rd_data_ff;
   logic                     kind_ff;
   logic [ist_pkg::IV_W-1:0] interval_ff;
   logic [ist_pkg::ID_W-1:0] target_ff;
   logic [ist_pkg::IV_W-1:0] min_ff, min_in;
   logic                     found_ff, found_in;
   logic [IW-1:0]            free_ff, free_in;
   logic                     hit_ff, hit_in;
   logic [CNTW-1:0]          count_ff, count_in;
   logic                     running_ff, running_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ist_pkg::ST_W-1:0] rsp_status_ff;
   logic [ist_pkg::ID_W-1:0] rsp_id_ff;
   logic                     rsp_active_ff;
   logic [ist_pkg::IV_W-1:0] rsp_min_ff;
   logic [ist_pkg::IV_W-1:0] rsp_wait_ff;

   logic                     is_sub;
   logic                     stored;
   logic                     removed;
   logic [CW-1:0]            target_cw;
   logic [CW-1:0]            rd_idx_cw;
   logic [CW-1:0]            free_cw;
   logic                     rd_used;
   logic [ist_pkg::IV_W-1:0] rd_iv;
   logic                     rd_is_target;
   logic [ist_pkg::IV_W-1:0] min_out;
   logic [ist_pkg::IV_W-1:0] wait_out;
   logic [ist_pkg::ST_W-1:0] status_out;
   logic [ist_pkg::ID_W-1:0] id_out;
   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   logic [MW-1:0]            wr_data;

   assign is_sub    = (kind_ff == ist_pkg::KIND_SUB);
   assign stored    = is_sub && found_ff;
   assign removed   = !is_sub && hit_ff;
   assign target_cw = CW'(target_ff);
   assign rd_idx_cw = CW'(rd_idx_ff);
   assign free_cw   = CW'(free_ff);
   assign rd_used   = rd_data_ff[MW-1];
   assign rd_iv     = rd_data_ff[ist_pkg::IV_W-1:0];
   assign rd_is_target = (rd_idx_cw == target_cw);

   assign sts.addr_last = (addr_ff == IW'(MAX_ENTRIES - 1));
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;

   // scan accumulation and slot address
   always_comb begin
      addr_in    = addr_ff;
      rd_pend_in = cmd.scan;
      min_in     = min_ff;
      found_in   = found_ff;
      free_in    = free_ff;
      hit_in     = hit_ff;
      if (cmd.start) begin
         addr_in  = '0;
         min_in   = ist_pkg::IV_ALL_ONES;
         found_in = 1'b0;
         free_in  = '0;
         hit_in   = 1'b0;
      end else if (cmd.clear || cmd.scan) begin
         addr_in = addr_ff + IW'(1);
      end
      if (rd_pend_ff) begin
         // the entry being removed does not count toward the minimum
         if (rd_used && !(!is_sub && rd_is_target) && (rd_iv < min_ff)) begin
            min_in = rd_iv;
         end
         if (!rd_used && !found_ff) begin
            found_in = 1'b1;
            free_in  = rd_idx_ff;
         end
         if (rd_used && rd_is_target) begin
            hit_in = 1'b1;
         end
      end
   end

   // table update and result
   always_comb begin
      min_out  = (stored && (interval_ff < min_ff)) ? interval_ff : min_ff;
      wait_out = (min_out < max_wait_us) ? min_out : max_wait_us;
      id_out   = stored ? free_cw[ist_pkg::ID_W-1:0] : '0;
      if (is_sub) begin
         status_out = found_ff ? ist_pkg::ST_OK : ist_pkg::ST_FULL;
      end else begin
         status_out = hit_ff ? ist_pkg::ST_OK : ist_pkg::ST_NOT_SUB;
      end
      count_in   = count_ff;
      running_in = running_ff;
      if (cmd.commit) begin
         if (stored) begin
            count_in = count_ff + CNTW'(1);
         end else if (removed) begin
            count_in = count_ff - CNTW'(1);
         end
         if (is_sub) begin
            running_in = 1'b1;
         end else if (count_in == '0) begin
            running_in = 1'b0;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      wr_en   = cmd.clear || (cmd.commit && (stored || removed));
      wr_addr = target_cw[IW-1:0];
      wr_data = '0;
      if (cmd.clear) begin
         wr_addr = addr_ff;
      end else if (stored) begin
         wr_addr = free_ff;
         wr_data = {1'b1, interval_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         count_ff     <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         rd_pend_ff   <= rd_pend_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      min_ff    <= min_in;
      found_ff  <= found_in;
      free_ff   <= free_in;
      hit_ff    <= hit_in;
      if (cmd.start) begin
         kind_ff     <= req_kind;
         interval_ff <= req_interval_us;
         target_ff   <= req_target_id;
      end
      if (cmd.commit) begin
         rsp_status_ff <= status_out;
         rsp_id_ff     <= id_out;
         rsp_active_ff <= running_in;
         rsp_min_ff    <= min_out;
         rsp_wait_ff   <= wait_out;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_assigned_id      = rsp_id_ff;
   assign rsp_active           = rsp_active_ff;
   assign rsp_min_interval_us  = rsp_min_ff;
   assign rsp_wait_interval_us = rsp_wait_ff;

endmodule

### tb/sv/tb_interval_subscription_table.sv
// self-checking testbench for the interval subscription table
module tb_interval_subscription_table;

   localparam int unsigned MAX_ENTRIES    = 64;
   localparam int unsigned RESULT_LATENCY = MAX_ENTRIES + 3;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned PHASE_ITEMS    = 270;
   localparam logic [ist_pkg::CSR_AW-1:0] MAX_WAIT_ADDR = {ist_pkg::REG_MAX_WAIT, 2'b00};

   typedef struct packed {
      logic                     kind;
      logic [ist_pkg::IV_W-1:0] interval_us;
      logic [ist_pkg::ID_W-1:0] target_id;
   } request_type;

   typedef struct packed {
      logic [ist_pkg::ST_W-1:0] status;
      logic [ist_pkg::ID_W-1:0] assigned_id;
      logic                     active;
      logic [ist_pkg::IV_W-1:0] min_us;
      logic [ist_pkg::IV_W-1:0] wait_us;
   } outcome_type;

   typedef struct {
      request_type req;
      bit          typed;
      outcome_type want;
   } directed_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_kind;
   logic [ist_pkg::IV_W-1:0]   req_interval_us;
   logic [ist_pkg::ID_W-1:0]   req_target_id;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [ist_pkg::ST_W-1:0]   rsp_status;
   logic [ist_pkg::ID_W-1:0]   rsp_assigned_id;
   logic                       rsp_active;
   logic [ist_pkg::IV_W-1:0]   rsp_min_interval_us;
   logic [ist_pkg::IV_W-1:0]   rsp_wait_interval_us;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [ist_pkg::CSR_AW-1:0] csr_paddr;
   logic [ist_pkg::CSR_DW-1:0] csr_pwdata;
   logic [ist_pkg::CSR_DW-1:0] csr_prdata;
   logic                       csr_pready;

   // shadow of the subscriber table
   logic [ist_pkg::ID_W-1:0] slot_id [MAX_ENTRIES];
   logic [ist_pkg::IV_W-1:0] slot_iv [MAX_ENTRIES];
   int unsigned              slot_count;
   bit                       timer_running;
   logic [ist_pkg::IV_W-1:0] cap_us;

   outcome_type        pending_results[$];
   directed_row_type   directed_rows[$];

   int unsigned error_count;
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned hold_requests;
   int unsigned hold_served;
   int unsigned subscribe_count;
   int unsigned unsubscribe_count;
   int unsigned full_count;
   int unsigned unknown_id_count;
   int unsigned empty_count;
   int unsigned cap_writes;
   int unsigned idle_cycles;

   interval_subscription_table #(.MAX_ENTRIES(MAX_ENTRIES)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic outcome_type apply_request(input request_type r);
      outcome_type          res;
      bit [MAX_ENTRIES-1:0] taken;
      int unsigned          free_id;
      int unsigned          i;
      bit                   hit;
      res = '0;
      res.status = ist_pkg::ST_OK;
      if (r.kind == ist_pkg::KIND_SUB) begin
         timer_running = 1'b1;
         taken = '0;
         for (i = 0; i < slot_count; i++) taken[slot_id[i]] = 1'b1;
         free_id = 0;
         while (free_id < MAX_ENTRIES && taken[free_id]) free_id++;
         if (free_id >= MAX_ENTRIES || slot_count >= MAX_ENTRIES) begin
            res.status = ist_pkg::ST_FULL;
         end else begin
            slot_id[slot_count] = ist_pkg::ID_W'(free_id);
            slot_iv[slot_count] = r.interval_us;
            slot_count++;
            res.assigned_id = ist_pkg::ID_W'(free_id);
         end
      end else begin
         hit = 1'b0;
         for (i = 0; i < slot_count && !hit; i++) begin
            if (slot_id[i] == r.target_id) begin
               // last entry moves into the freed slot
               slot_id[i] = slot_id[slot_count-1];
               slot_iv[i] = slot_iv[slot_count-1];
               slot_count--;
               hit = 1'b1;
            end
         end
         if (slot_count == 0) timer_running = 1'b0;
         if (!hit) res.status = ist_pkg::ST_NOT_SUB;
      end
      res.min_us = ist_pkg::IV_ALL_ONES;
      for (i = 0; i < slot_count; i++) begin
         if (slot_iv[i] < res.min_us) res.min_us = slot_iv[i];
      end
      res.wait_us = (res.min_us < cap_us) ? res.min_us : cap_us;
      res.active = timer_running;
      return res;
   endfunction

   function automatic logic [ist_pkg::IV_W-1:0] pick_interval();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50) return $urandom();
      if (sel < 70) return $urandom_range(2000000);
      if (sel < 80) return sel[0] ? ist_pkg::IV_ALL_ONES : '0;
      return cap_us + $urandom_range(4) - 2;
   endfunction

   function automatic logic [ist_pkg::ID_W-1:0] pick_target();
      if (slot_count != 0 && $urandom_range(99) < 80)
         return slot_id[$urandom_range(slot_count - 1)];
      return ist_pkg::ID_W'($urandom_range(63));
   endfunction

   task automatic offer(input request_type r, input bit typed, input outcome_type want);
      outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= r.kind;
      req_interval_us <= r.interval_us;
      req_target_id   <= r.target_id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_request(r);
      if (r.kind == ist_pkg::KIND_SUB) subscribe_count++;
      else unsubscribe_count++;
      if (predicted.status == ist_pkg::ST_FULL) full_count++;
      if (predicted.status == ist_pkg::ST_NOT_SUB) unknown_id_count++;
      if (!predicted.active) empty_count++;
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_wait(input logic [ist_pkg::IV_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_WAIT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cap_us = value;
      cap_writes++;
      // read back in a second transfer
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value) begin
         error_count++;
         if (error_count <= 10)
            $display("max_wait_us readback: expected %0d, got %0d", value, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_row(input logic kind, input logic [ist_pkg::IV_W-1:0] iv,
                          input logic [ist_pkg::ID_W-1:0] tid, input bit typed,
                          input outcome_type want);
      directed_row_type row;
      row.req   = {kind, iv, tid};
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned n;
      int unsigned run_left;
      int unsigned sub_pct;
      bit          filling;
      request_type r;
      filling  = 1'b0;
      run_left = 0;
      for (n = 0; n < count; n++) begin
         if (run_left == 0) begin
            filling  = !filling;
            run_left = filling ? $urandom_range(140, 40) : $urandom_range(100, 20);
         end
         run_left--;
         sub_pct = filling ? 90 : 12;
         if ($urandom_range(99) < 10) begin
            // noise: any kind, any id
            r = {1'($urandom_range(1)), 32'($urandom()), 6'($urandom_range(63))};
         end else if ($urandom_range(99) < sub_pct) begin
            r = {ist_pkg::KIND_SUB, pick_interval(), 6'($urandom_range(63))};
         end else begin
            r = {ist_pkg::KIND_UNSUB, 32'($urandom()), pick_target()};
         end
         if (n == 120 && send_idle_pct == 0 && stall_pct == 0) hold_requests++;
         if (n == 200) wait_drained();
         offer(r, 1'b0, '0);
      end
   endtask

   // response side: stalls, long hold-off and checking
   initial begin : response_side
      int unsigned hold_left;
      outcome_type want;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response: status %0d id %0d", rsp_status,
                           rsp_assigned_id);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status || rsp_assigned_id !== want.assigned_id ||
                   rsp_active !== want.active || rsp_min_interval_us !== want.min_us ||
                   rsp_wait_interval_us !== want.wait_us) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("mismatch: expected status %0d id %0d active %0d min %0d wait %0d",
                              want.status, want.assigned_id, want.active, want.min_us,
                              want.wait_us);
                     $display("          got      status %0d id %0d active %0d min %0d wait %0d",
                              rsp_status, rsp_assigned_id, rsp_active, rsp_min_interval_us,
                              rsp_wait_interval_us);
                  end
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned              i;
      int unsigned              phase;
      logic [ist_pkg::IV_W-1:0] caps [4];
      outcome_type              empty_miss;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= ist_pkg::KIND_SUB;
      req_interval_us <= '0;
      req_target_id   <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      slot_count      = 0;
      timer_running   = 1'b0;
      cap_us          = ist_pkg::MAX_WAIT_RESET;
      error_count     = 0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      hold_requests   = 0;
      hold_served     = 0;
      subscribe_count = 0;
      unsubscribe_count = 0;
      full_count      = 0;
      unknown_id_count = 0;
      empty_count     = 0;
      cap_writes      = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      empty_miss = {ist_pkg::ST_NOT_SUB, 6'd0, 1'b0, ist_pkg::IV_ALL_ONES,
                    ist_pkg::MAX_WAIT_RESET};
      add_row(ist_pkg::KIND_UNSUB, '0, 6'd0, 1'b1, empty_miss);
      add_row(ist_pkg::KIND_UNSUB, '1, 6'd63, 1'b1, empty_miss);
      add_row(ist_pkg::KIND_SUB, ist_pkg::IV_ALL_ONES, '0, 1'b1,
              {ist_pkg::ST_OK, 6'd0, 1'b1, ist_pkg::IV_ALL_ONES, ist_pkg::MAX_WAIT_RESET});
      add_row(ist_pkg::KIND_SUB, '0, '1, 1'b1, {ist_pkg::ST_OK, 6'd1, 1'b1, 32'd0, 32'd0});
      add_row(ist_pkg::KIND_SUB, 32'h5555_5555, '0, 1'b0, '0);
      add_row(ist_pkg::KIND_SUB, 32'hAAAA_AAAA, '0, 1'b0, '0);
      add_row(ist_pkg::KIND_UNSUB, '0, 6'd63, 1'b1,
              {ist_pkg::ST_NOT_SUB, 6'd0, 1'b1, 32'd0, 32'd0});
      add_row(ist_pkg::KIND_UNSUB, '0, 6'd1, 1'b0, '0);
      add_row(ist_pkg::KIND_SUB, 32'd999999, '0, 1'b0, '0);
      add_row(ist_pkg::KIND_SUB, 32'd1000000, '0, 1'b0, '0);
      add_row(ist_pkg::KIND_SUB, 32'd1000001, '0, 1'b0, '0);
      add_row(ist_pkg::KIND_SUB, 32'd1, '0, 1'b0, '0);
      add_row(ist_pkg::KIND_UNSUB, '0, 6'd6, 1'b0, '0);
      for (i = 0; i < 6; i++) add_row(ist_pkg::KIND_UNSUB, '1, ist_pkg::ID_W'(i), 1'b0, '0);
      // table is empty again, running flag drops
      add_row(ist_pkg::KIND_UNSUB, '0, 6'd1, 1'b1, empty_miss);
      add_row(ist_pkg::KIND_SUB, 32'd42, '0, 1'b1,
              {ist_pkg::ST_OK, 6'd0, 1'b1, 32'd42, 32'd42});
      add_row(ist_pkg::KIND_UNSUB, '0, 6'd0, 1'b1,
              {ist_pkg::ST_OK, 6'd0, 1'b0, ist_pkg::IV_ALL_ONES, ist_pkg::MAX_WAIT_RESET});
      foreach (directed_rows[k])
         offer(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);
      wait_drained();

      caps[0] = 32'd1;
      caps[1] = 32'hFFFF_FFFF;
      caps[2] = $urandom_range(5000000, 1);
      caps[3] = $urandom() | 32'd1;
      for (phase = 0; phase < 4; phase++) begin
         wait_drained();
         write_max_wait(caps[phase]);
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      repeat (RESULT_LATENCY + 10) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0d responses never arrived", pending_results.size());
      end
      $display("covered %0d subscribe and %0d unsubscribe requests over %0d max_wait settings",
               subscribe_count, unsubscribe_count, cap_writes);
      $display("table full %0d times, unknown id %0d times, inactive after %0d requests",
               full_count, unknown_id_count, empty_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
